// File: rtl/rsa_modular_exponentiation_macros.svh
// Assertion macros used by the modular multiplier of the modular exponentiation RTL.
`ifndef RSA_MODULAR_EXPONENTIATION_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define RME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define RME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rme_pkg.sv
// Package: sizes, register indexes and beat types of the modular exponentiation block.
`default_nettype none
package rme_pkg;
    localparam int WORD_BITS    = 31;
    localparam int EXP_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int MM_CNT_BITS  = $clog2(WORD_BITS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = CFG_IDX_BITS'(1);

    localparam logic [EXP_BITS-1:0]  EXP_RESET = EXP_BITS'(65537);
    localparam logic [WORD_BITS-1:0] MOD_RESET = WORD_BITS'(1);

    typedef struct packed {
        logic [WORD_BITS-1:0] message_value;
        logic                 last_in;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_BITS-1:0] result_value;
        logic                 last_out;
    } t_out_beat;
endpackage
`default_nettype wire

// File: rtl/rme_modmul.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none
`include "rsa_modular_exponentiation_macros.svh"
module rme_modmul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rme_pkg::WORD_BITS-1:0] i_x,
    input  wire logic [rme_pkg::WORD_BITS-1:0] i_y,
    input  wire logic [rme_pkg::WORD_BITS-1:0] i_n,
    output logic                               o_done,
    output logic [rme_pkg::WORD_BITS-1:0]      o_prod
);
    localparam int WB = rme_pkg::WORD_BITS;
    localparam int CB = rme_pkg::MM_CNT_BITS;

    logic [WB-1:0] r_acc, n_acc;
    logic [WB-1:0] r_x;
    logic [WB-1:0] r_y;
    logic [CB-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [WB:0] dbl, dbl_red, sum, sum_red, n_ext;

    // acc = (2*acc + ybit*x) mod n; acc, x < n so each half needs one subtract
    always_comb begin
        n_ext   = {1'b0, i_n};
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum     = dbl_red + (r_y[WB-1] ? {1'b0, r_x} : '0);
        sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
        n_acc   = sum_red[WB-1:0];
    end

    // Payload: accumulator and operand shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WB-2:0], 1'b0};
        end
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CB'(1);
                if (r_cnt == CB'(WB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `RME_ASSERT_NOW(a_acc_reduced, r_busy, r_acc < i_n, "accumulator not below modulus")
    `RME_ASSERT_NOW(a_no_restart, i_start, !r_busy, "start while a product is in progress")
    `RME_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "done held longer than one cycle")
endmodule
`default_nettype wire

// File: rtl/rsa_modular_exponentiation.sv
// With a modulus of 0 or 1 the sequencer goes from idle to the output state with a result of 0.
// Otherwise a product reduces the word, then each exponent bit up to the highest set one
// takes a square, or a multiply and a square; the top set bit skips its square. One word
// is in flight; a result waits in an output register. Synchronous active-low reset sets
// exponent 65537 and modulus 1.
`default_nettype none
module rsa_modular_exponentiation (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire rme_pkg::t_in_beat                 i_in_beat,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output rme_pkg::t_out_beat                     o_out_beat,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rme_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [rme_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int WB = rme_pkg::WORD_BITS;
    localparam int EB = rme_pkg::EXP_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_BIT  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [EB-1:0]       r_exponent;
    logic [WB-1:0]       r_modulus;
    logic [WB-1:0]       r_base, n_base;
    logic [WB-1:0]       r_acc, n_acc;
    logic [EB-1:0]       r_exp, n_exp;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    rme_pkg::t_out_beat  r_out, n_out;

    logic          mm_start, mm_done;
    logic [WB-1:0] mm_x, mm_y, mm_prod;
    logic          in_acc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= rme_pkg::EXP_RESET;
            r_modulus  <= rme_pkg::MOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rme_pkg::REG_EXPONENT: r_exponent <= i_cfg_data[EB-1:0];
                rme_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data[WB-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: reduce, then right-to-left square and multiply
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mm_start    = 1'b0;
        mm_x        = r_base;
        mm_y        = r_base;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_beat.last_in;
                    n_exp  = r_exponent;
                    if (r_modulus <= WB'(1)) begin
                        n_acc   = '0;
                        n_state = ST_OUT;
                    end else begin
                        mm_start = 1'b1;
                        mm_x     = WB'(1);
                        mm_y     = i_in_beat.message_value;
                        n_state  = ST_RED;
                    end
                end
            end
            ST_RED: begin
                if (mm_done) begin
                    n_base  = mm_prod;
                    n_acc   = WB'(1);
                    n_state = ST_BIT;
                end
            end
            ST_BIT: begin
                if (r_exp == '0) begin
                    n_state = ST_OUT;
                end else if (r_exp[0]) begin
                    mm_start = 1'b1;
                    mm_x     = r_acc;
                    n_state  = ST_MUL;
                end else begin
                    mm_start = 1'b1;
                    n_state  = ST_SQR;
                end
            end
            ST_MUL: begin
                if (mm_done) begin
                    n_acc = mm_prod;
                    // no higher exponent bit left: the square is not needed
                    if (r_exp[EB-1:1] == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        mm_start = 1'b1;
                        n_state  = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mm_done) begin
                    n_base  = mm_prod;
                    n_exp   = {1'b0, r_exp[EB-1:1]};
                    n_state = ST_BIT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = r_acc;
                    n_out.last_out     = r_last;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_acc  <= n_acc;
        r_exp  <= n_exp;
        r_last <= n_last;
        r_out  <= n_out;
    end

    rme_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_n     (r_modulus),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );
endmodule
`default_nettype wire
